// ----- hw/rtl/sosmme_pkg.sv -----
package sosmme_pkg;

    // default sizes of the surface
    localparam int SITES_DEF       = 256;
    localparam int HEIGHT_BITS_DEF = 16;

    // fixed field widths
    localparam int SITE_IN_W = 8;
    localparam int NEW_H_W   = 16;
    localparam int OUT_H_W   = 16;
    localparam int ENERGY_W  = 24;
    localparam int RAND_W    = 32;

    // threshold register bank
    localparam int NUM_THR   = 8;
    localparam int THR_W     = 33;
    localparam int CFG_IDX_W = 3;
    localparam logic [THR_W-1:0] THR_RESET = 33'h1_0000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_GLAU_DROP_RAISE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLAU_FLAT_RAISE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GLAU_RISE_RAISE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GLAU_DROP_LOWER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GLAU_FLAT_LOWER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GLAU_RISE_LOWER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KAW_RISE_TWO    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_KAW_RISE_FOUR   = 3'd7;

    // item kinds
    localparam logic [1:0] MODE_GLAUBER  = 2'd0;
    localparam logic [1:0] MODE_KAWASAKI = 2'd1;
    localparam logic [1:0] MODE_WRITE    = 2'd2;
    localparam logic [1:0] MODE_READ     = 2'd3;

    typedef struct packed {
        logic [1:0]           mode;
        logic [SITE_IN_W-1:0] site;
        logic                 step_sign;
        logic                 direction;
        logic [RAND_W-1:0]    random_fraction;
        logic [NEW_H_W-1:0]   new_height;
    } t_in;

    typedef struct packed {
        logic                accepted;
        logic                blocked;
        logic [OUT_H_W-1:0]  site_height;
        logic [ENERGY_W-1:0] total_energy;
    } t_out;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [THR_W-1:0]     data;
    } t_cfg_wr;

endpackage

// ----- hw/rtl/sos_metropolis_move_engine.sv -----
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_stall   i_in_data  (t_in)
// out       output     o_out_valid / i_out_stall o_out_data (t_out)
// cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// an item passes from acceptance to its result register through the second
// dual-port read pair, a difference stage, a sum stage, the decision with the
// column write-back, then the partner write with the hand-over; the next item
// is taken only after the hand-over, as o_in_stall is high outside idle.
// after reset the memory is cleared site by site under o_in_stall; config taken.
// a result waiting under i_out_stall holds the next item at its hand-over.
module sos_metropolis_move_engine #(
    parameter int SITES       = sosmme_pkg::SITES_DEF,
    parameter int HEIGHT_BITS = sosmme_pkg::HEIGHT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  sosmme_pkg::t_in                   i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output sosmme_pkg::t_out                  o_out_data,
    input  logic                              i_cfg_we,
    input  logic [sosmme_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sosmme_pkg::THR_W-1:0]      i_cfg_data
);
    import sosmme_pkg::*;

    localparam int SW  = $clog2(SITES);
    localparam int HB  = HEIGHT_BITS;
    localparam int DW  = HB + 3;
    localparam int EW  = (DW > ENERGY_W) ? DW : ENERGY_W;
    localparam int NHW = HB + NEW_H_W;
    localparam int MW  = 25;
    localparam logic [HB-1:0] LIMIT = '1;
    localparam logic [SW-1:0] LAST  = SW'(SITES - 1);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_EVAL  = 7'b0001000,
        ST_SUM   = 7'b0010000,
        ST_APPLY = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } t_state;

    // column index modulo the ring length, by constant long division
    function automatic logic [SW-1:0] site_mod(input logic [SITE_IN_W-1:0] s);
        logic [MW-1:0] v;
        v = MW'(s);
        for (int k = 7; k >= 0; k--) begin
            if (v >= (MW'(SITES) << k)) begin
                v = v - (MW'(SITES) << k);
            end
        end
        return SW'(v);
    endfunction

    function automatic logic [SW-1:0] ring_inc(input logic [SW-1:0] a);
        return (a == LAST) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [SW-1:0] ring_dec(input logic [SW-1:0] a);
        return (a == '0) ? LAST : a - 1'b1;
    endfunction

    function automatic logic [HB-1:0] absd(input logic [HB-1:0] p, input logic [HB-1:0] q);
        return (p > q) ? p - q : q - p;
    endfunction

    t_state                 r_state, n_state;
    logic   [SW-1:0]        r_clr;
    t_in                    r_item;
    logic   [SW-1:0]        r_x, r_b, r_c, r_e;
    logic   [HB-1:0]        r_ha, r_hb;
    logic   [HB-1:0]        r_anew, r_bnew;
    logic                   r_blk;
    logic   [HB-1:0]        r_t0, r_t1, r_t2, r_i0, r_i1, r_i2;
    logic signed [DW-1:0]   r_d;
    logic   [ENERGY_W-1:0]  r_energy;
    logic                   r_res_acc, r_res_blk;
    logic   [HB-1:0]        r_res_h;
    logic                   r_out_valid;
    t_out                   r_out;

    logic                   in_acc;
    logic   [SW-1:0]        x_in, b_in, c_in, e_in;
    logic                   pos_in;
    logic                   ram_we;
    logic   [SW-1:0]        ram_waddr, ram_raddr0, ram_raddr1;
    logic   [HB-1:0]        ram_wdata, rd0, rd1;
    logic   [CFG_IDX_W-1:0] thr_sel;
    logic                   below;
    logic                   acc;
    logic                   is_glau, is_kaw, is_write;
    logic   [HB-1:0]        a_new, b_new;
    logic                   blk;
    logic   [DW-1:0]        ef, ei;
    logic signed [EW-1:0]   d_ext;
    logic                   out_free;
    t_cfg_wr                cfg_wr;

    assign is_glau  = (r_item.mode == MODE_GLAUBER);
    assign is_kaw   = (r_item.mode == MODE_KAWASAKI);
    assign is_write = (r_item.mode == MODE_WRITE);

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // ring addresses: b is the partner side, c the far side of x, e beyond b
    always_comb begin
        pos_in = (i_in_data.mode == MODE_KAWASAKI) ? i_in_data.direction : 1'b1;
        x_in   = site_mod(i_in_data.site);
        b_in   = pos_in ? ring_inc(x_in) : ring_dec(x_in);
        c_in   = pos_in ? ring_dec(x_in) : ring_inc(x_in);
        e_in   = pos_in ? ring_inc(b_in) : ring_dec(b_in);
    end

    // height memory ports
    always_comb begin
        ram_raddr0 = r_c;
        ram_raddr1 = r_e;
        if (r_state == ST_IDLE) begin
            ram_raddr0 = x_in;
            ram_raddr1 = b_in;
        end
        ram_we    = 1'b0;
        ram_waddr = r_x;
        ram_wdata = r_anew;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            ST_APPLY: begin
                ram_we = acc;
            end
            ST_EMIT: begin
                ram_we    = r_res_acc && is_kaw;
                ram_waddr = r_b;
                ram_wdata = r_bnew;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    sosmme_ram #(
        .WIDTH (HB),
        .DEPTH (SITES)
    ) u_heights (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_raddr0 (ram_raddr0),
        .o_rdata0 (rd0),
        .i_raddr1 (ram_raddr1),
        .o_rdata1 (rd1)
    );

    // proposed heights and range check, old neighbours from the second read
    always_comb begin
        a_new = r_item.step_sign ? r_ha + 1'b1 : r_ha - 1'b1;
        b_new = r_hb;
        blk   = 1'b0;
        case (r_item.mode)
            MODE_GLAUBER: begin
                blk = r_item.step_sign ? (r_ha == LIMIT) : (r_ha == '0);
            end
            MODE_KAWASAKI: begin
                b_new = r_item.step_sign ? r_hb - 1'b1 : r_hb + 1'b1;
                blk   = r_item.step_sign ? ((r_ha == LIMIT) || (r_hb == '0))
                                         : ((r_ha == '0) || (r_hb == LIMIT));
            end
            MODE_WRITE: begin
                a_new = HB'(NHW'(r_item.new_height));
                blk   = (NHW'(r_item.new_height) > NHW'(LIMIT));
            end
            default: begin
                a_new = r_ha;
            end
        endcase
    end

    // energy change from the local bond terms
    assign ef = DW'(r_t0) + DW'(r_t1) + DW'(r_t2);
    assign ei = DW'(r_i0) + DW'(r_i1) + DW'(r_i2);

    // threshold choice for the metropolis test
    always_comb begin
        thr_sel = REG_KAW_RISE_FOUR;
        if (is_glau) begin
            if (r_item.step_sign) begin
                thr_sel = (r_d < 0) ? REG_GLAU_DROP_RAISE :
                          (r_d == 0) ? REG_GLAU_FLAT_RAISE : REG_GLAU_RISE_RAISE;
            end else begin
                thr_sel = (r_d < 0) ? REG_GLAU_DROP_LOWER :
                          (r_d == 0) ? REG_GLAU_FLAT_LOWER : REG_GLAU_RISE_LOWER;
            end
        end else if (r_d == 2) begin
            thr_sel = REG_KAW_RISE_TWO;
        end
    end

    assign cfg_wr = '{we: i_cfg_we, index: i_cfg_index, data: i_cfg_data};

    sosmme_thresholds u_thr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_wr),
        .i_sel   (thr_sel),
        .i_rnd   (r_item.random_fraction),
        .o_below (below)
    );

    assign acc = !r_blk && (is_write || (is_glau && below)
                            || (is_kaw && ((r_d <= 0) || below)));
    assign d_ext = EW'(r_d);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: n_state = (r_clr == LAST) ? ST_IDLE : ST_CLEAR;
            ST_IDLE:  n_state = in_acc ? ST_READ : ST_IDLE;
            ST_READ:  n_state = ST_EVAL;
            ST_EVAL:  n_state = ST_SUM;
            ST_SUM:   n_state = ST_APPLY;
            ST_APPLY: n_state = ST_EMIT;
            ST_EMIT:  n_state = out_free ? ST_IDLE : ST_EMIT;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_energy    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if ((r_state == ST_APPLY) && acc) begin
                r_energy <= r_energy + d_ext[ENERGY_W-1:0];
            end
            if ((r_state == ST_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
            r_x    <= x_in;
            r_b    <= b_in;
            r_c    <= c_in;
            r_e    <= e_in;
        end
        if (r_state == ST_READ) begin
            r_ha <= rd0;
            r_hb <= rd1;
        end
        if (r_state == ST_EVAL) begin
            r_anew <= a_new;
            r_bnew <= b_new;
            r_blk  <= blk;
            r_t0   <= absd(a_new, rd0);
            r_t1   <= absd(a_new, b_new);
            r_t2   <= is_kaw ? absd(b_new, rd1) : '0;
            r_i0   <= absd(r_ha, rd0);
            r_i1   <= absd(r_ha, r_hb);
            r_i2   <= is_kaw ? absd(r_hb, rd1) : '0;
        end
        if (r_state == ST_SUM) begin
            r_d <= $signed(ef - ei);
        end
        if (r_state == ST_APPLY) begin
            r_res_acc <= acc;
            r_res_blk <= r_blk;
            r_res_h   <= acc ? r_anew : r_ha;
        end
        if ((r_state == ST_EMIT) && out_free) begin
            r_out.accepted     <= r_res_acc;
            r_out.blocked      <= r_res_blk;
            r_out.site_height  <= OUT_H_W'(r_res_h);
            r_out.total_energy <= r_energy;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a result is never both applied and blocked
    a_acc_blk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.accepted && o_out_data.blocked))
        else $error("result both accepted and blocked");

    // heights are written only by the clearing pass or an applied item
    a_ram_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == ST_CLEAR) || (r_state == ST_APPLY)
                    || (r_state == ST_EMIT)))
        else $error("height write outside its stages");

    // energy moves only at the decision stage
    a_energy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_APPLY) |=> $stable(r_energy))
        else $error("energy changed outside the decision stage");

    // an accepted transaction starts the read sequence
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_READ))
        else $error("accepted transaction did not start reading");

endmodule

// ----- hw/rtl/sosmme_ram.sv -----
module sosmme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    output logic [WIDTH-1:0]         o_rdata0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= mem[i_raddr0];
        o_rdata1 <= mem[i_raddr1];
    end

endmodule

// ----- hw/rtl/sosmme_thresholds.sv -----
module sosmme_thresholds (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sosmme_pkg::t_cfg_wr                 i_cfg,
    input  logic [sosmme_pkg::CFG_IDX_W-1:0]    i_sel,
    input  logic [sosmme_pkg::RAND_W-1:0]       i_rnd,
    output logic                                o_below
);
    import sosmme_pkg::*;

    logic [THR_W-1:0] r_thr [NUM_THR];

    // register bank, to be written only while the engine is idle; the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_THR; k++) begin
                r_thr[k] <= THR_RESET;
            end
        end else if (i_cfg.we) begin
            r_thr[i_cfg.index] <= i_cfg.data;
        end
    end

    // metropolis test: random fraction below the chosen threshold
    assign o_below = ({1'b0, i_rnd} < r_thr[i_sel]);

endmodule
